[rtl/core/mee_pkg.sv]
// Shared types, constants and entity tables for the markup entity escaper.
// Used by every module of the block; depends on nothing.
package mee_pkg;

   localparam int CharWidth   = 16;
   localparam int EntCount    = 8;
   localparam int EntMaxLen   = 6;
   localparam int EntIdxWidth = $clog2(EntCount);
   localparam int PosWidth    = $clog2(EntMaxLen + 1);

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // Register indexes on the configuration port.
   localparam logic REG_ENTITY_MASK = 1'b0;

   localparam logic [EntCount-1:0] MaskReset = 8'hFF;

   // Code unit that each entity replaces; entry i is enabled by mask bit i.
   localparam logic [CharWidth-1:0] EntCode [EntCount] = '{
      16'h0026, 16'h003C, 16'h003E, 16'h0022,
      16'h00A0, 16'h0009, 16'h000A, 16'h000D
   };

   localparam logic [PosWidth-1:0] EntLen [EntCount] = '{
      3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5, 3'd5
   };

   // Entity text, first character in the lowest byte.
   localparam logic [8*EntMaxLen-1:0] EntText [EntCount] = '{
      48'h00_3B_70_6D_61_26,   // &amp;
      48'h00_00_3B_74_6C_26,   // &lt;
      48'h00_00_3B_74_67_26,   // &gt;
      48'h3B_74_6F_75_71_26,   // &quot;
      48'h3B_70_73_62_6E_26,   // &nbsp;
      48'h00_00_3B_39_23_26,   // &#9;
      48'h00_3B_30_31_23_26,   // &#10;
      48'h00_3B_33_31_23_26    // &#13;
   };

   typedef struct packed {
      logic                   is_ent;
      logic [EntIdxWidth-1:0] idx;
   } class_type;

   function automatic logic [CharWidth-1:0] entity_char(
      input logic [EntIdxWidth-1:0] idx,
      input logic [PosWidth-1:0]    pos
   );
      logic [8*EntMaxLen-1:0] text;
      logic [7:0]             c;
      text = EntText[idx];
      c    = 8'h00;
      for (int k = 0; k < EntMaxLen; k++) begin
         if (pos == PosWidth'(k)) begin
            c = text[8*k +: 8];
         end
      end
      return {{(CharWidth-8){1'b0}}, c};
   endfunction

endpackage

[rtl/core/markup_entity_escaper_unit.sv]
// Markup entity escaper: one text code unit in per request; enabled escapable
// characters come out as their entity strings (4 to 6 units), all others pass through
// as one unit. Plain requests are taken at one request per cycle while the result side
// is not stalled; an entity holds its request until its last character has moved to the
// result register, and the holding register takes the next request in that same cycle.
// A request passes through the holding register and then the result register. tlast on
// the result side marks the last unit of each request; tuser carries the end-of-text flag
// on that unit. Depends on mee_pkg, mee_csr, mee_classify and mee_emit.
module markup_entity_escaper_unit
   import mee_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [CharWidth-1:0]    req_tdata,   // [15:0] char_code
   input  logic                    req_tlast,   // text_end
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [CharWidth-1:0]    rsp_tdata,   // [15:0] out_char
   output logic                    rsp_tlast,   // run_last
   output logic [0:0]              rsp_tuser,   // [0] out_text_end
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic [EntCount-1:0] entity_mask;
   class_type           req_class;

   mee_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entity_mask (entity_mask)
   );

   mee_classify u_classify (
      .char_code   (req_tdata),
      .entity_mask (entity_mask),
      .char_class  (req_class)
   );

   mee_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_end    (req_tlast),
      .req_class  (req_class),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_end    (rsp_tuser[0])
   );

endmodule

[rtl/core/mee_csr.sv]
// Configuration register file: holds the entity enable mask behind an APB-style port.
// Depends on mee_pkg.
module mee_csr
   import mee_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [EntCount-1:0]     entity_mask
);

   logic [EntCount-1:0] mask_ff;
   logic [EntCount-1:0] mask_in;
   logic                reg_idx;
   logic                wr_en;

   assign reg_idx    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mask_in = mask_ff;
      if (wr_en && reg_idx == REG_ENTITY_MASK) begin
         mask_in = csr_pwdata[EntCount-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MaskReset;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_ENTITY_MASK) begin
         csr_prdata = {{(CsrDataWidth-EntCount){1'b0}}, mask_ff};
      end
   end

   assign entity_mask = mask_ff;

endmodule

[rtl/core/mee_classify.sv]
// Decides whether an incoming code unit is an enabled escapable character.
// Depends on mee_pkg.
module mee_classify
   import mee_pkg::*;
(
   input  logic [CharWidth-1:0] char_code,
   input  logic [EntCount-1:0]  entity_mask,
   output class_type            char_class
);

   always_comb begin
      char_class = '0;
      // Codes are distinct, so at most one entry matches.
      for (int i = EntCount - 1; i >= 0; i--) begin
         if (char_code == EntCode[i] && entity_mask[i]) begin
            char_class.is_ent = 1'b1;
            char_class.idx    = EntIdxWidth'(i);
         end
      end
   end

endmodule

[rtl/core/mee_emit.sv]
// Holding register and result register: expands a held request into one or more
// result units. Depends on mee_pkg.
module mee_emit
   import mee_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CharWidth-1:0] req_char,
   input  logic                 req_end,
   input  class_type            req_class,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CharWidth-1:0] rsp_char,
   output logic                 rsp_last,
   output logic                 rsp_end
);

   logic                 hold_valid_ff, hold_valid_in;
   logic [CharWidth-1:0] hold_char_ff, hold_char_in;
   logic                 hold_end_ff, hold_end_in;
   class_type            hold_class_ff, hold_class_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;

   logic                 out_valid_ff, out_valid_in;
   logic [CharWidth-1:0] out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_end_ff, out_end_in;

   logic out_free;
   logic unit_last;
   logic advance;
   logic release_hold;
   logic take;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign unit_last    = !hold_class_ff.is_ent ||
                         (pos_ff == EntLen[hold_class_ff.idx] - PosWidth'(1));
   assign advance      = hold_valid_ff && out_free;
   assign release_hold = advance && unit_last;
   assign req_tready   = !hold_valid_ff || release_hold;
   assign take         = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      hold_end_in   = hold_end_ff;
      hold_class_in = hold_class_ff;
      pos_in        = pos_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         hold_char_in  = req_char;
         hold_end_in   = req_end;
         hold_class_in = req_class;
         pos_in        = '0;
      end else if (release_hold) begin
         hold_valid_in = 1'b0;
      end else if (advance) begin
         pos_in = pos_ff + PosWidth'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = hold_class_ff.is_ent ?
                        entity_char(hold_class_ff.idx, pos_ff) : hold_char_ff;
         out_last_in  = unit_last;
         out_end_in   = unit_last && hold_end_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_char_ff  <= hold_char_in;
      hold_end_ff   <= hold_end_in;
      hold_class_ff <= hold_class_in;
      out_char_ff   <= out_char_in;
      out_last_ff   <= out_last_in;
      out_end_ff    <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_end    = out_end_ff;

endmodule

[tb/mee_stream_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the markup entity escaper: tracks the entity mask from the CSR port,
// expands every accepted request into its expected output units and compares results.
// Depends on mee_pkg for port widths and the register index.
module mee_stream_checker
   import mee_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [CharWidth-1:0]    req_tdata,   // [15:0] char_code
   input  logic                    req_tlast,   // text_end
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [CharWidth-1:0]    rsp_tdata,   // [15:0] out_char
   input  logic                    rsp_tlast,   // run_last
   input  logic [0:0]              rsp_tuser,   // [0] out_text_end
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   input  logic [CsrDataWidth-1:0] csr_prdata,
   input  logic                    csr_pready,
   output int                      mismatches,
   output int                      units_pending,
   output int                      requests_seen,
   output int                      units_seen
);

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 last;
      logic                 fin;
   } out_unit_type;

   out_unit_type         expected_units[$];
   logic [EntCount-1:0]  mask_copy;

   initial begin
      mismatches    = 0;
      units_pending = 0;
      requests_seen = 0;
      units_seen    = 0;
      mask_copy     = MaskReset;
   end

   // Slot of an escapable character, which is also its bit in the mask.
   function automatic int escape_slot(logic [CharWidth-1:0] code);
      case (code)
         16'h0026: return 0;
         16'h003C: return 1;
         16'h003E: return 2;
         16'h0022: return 3;
         16'h00A0: return 4;
         16'h0009: return 5;
         16'h000A: return 6;
         16'h000D: return 7;
         default:  return -1;
      endcase
   endfunction

   function automatic string entity_text(int slot);
      case (slot)
         0:       return "&amp;";
         1:       return "&lt;";
         2:       return "&gt;";
         3:       return "&quot;";
         4:       return "&nbsp;";
         5:       return "&#9;";
         6:       return "&#10;";
         default: return "&#13;";
      endcase
   endfunction

   function automatic void expand_unit(logic [CharWidth-1:0] code, logic fin);
      int           slot;
      string        txt;
      out_unit_type u;
      slot = escape_slot(code);
      if (slot >= 0 && mask_copy[slot]) begin
         txt = entity_text(slot);
         for (int k = 0; k < txt.len(); k++) begin
            u.ch   = {{(CharWidth-8){1'b0}}, txt[k]};
            u.last = (k == txt.len() - 1);
            u.fin  = u.last ? fin : 1'b0;
            expected_units.push_back(u);
         end
      end else begin
         u.ch   = code;
         u.last = 1'b1;
         u.fin  = fin;
         expected_units.push_back(u);
      end
   endfunction

   always @(posedge clock) begin
      out_unit_type want;
      if (reset) begin
         mask_copy = MaskReset;
      end else begin
         if (csr_psel && csr_penable && csr_pready
             && (csr_paddr >> 2) == CsrAddrWidth'(REG_ENTITY_MASK)) begin
            if (csr_pwrite) begin
               mask_copy = csr_pwdata[EntCount-1:0];
            end else if (csr_prdata !== CsrDataWidth'(mask_copy)) begin
               $display("%0t: mask read mismatch, expected %h, got %h",
                        $time, CsrDataWidth'(mask_copy), csr_prdata);
               mismatches++;
            end
         end
         if (req_tvalid && req_tready) begin
            expand_unit(req_tdata, req_tlast);
            requests_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            units_seen++;
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected result, expected none, got char %h last %b end %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser[0]);
               mismatches++;
            end else begin
               want = expected_units.pop_front();
               if (rsp_tdata !== want.ch || rsp_tlast !== want.last
                   || rsp_tuser[0] !== want.fin) begin
                  $display("%0t: result mismatch, expected char %h last %b end %b, %s %h %b %b",
                           $time, want.ch, want.last, want.fin, "got char/last/end",
                           rsp_tdata, rsp_tlast, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
      end
      units_pending = expected_units.size();
   end

endmodule

[tb/tb_markup_entity_escaper_unit.sv]
`timescale 1ns / 100ps
// Top of the markup entity escaper testbench: clock, reset, request and CSR stimulus,
// result backpressure and the verdict. Depends on mee_pkg, the RTL and mee_stream_checker.
module tb_markup_entity_escaper_unit;
   import mee_pkg::*;

   localparam logic [CsrAddrWidth-1:0] AddrMask  = CsrAddrWidth'(REG_ENTITY_MASK) << 2;
   localparam logic [CsrAddrWidth-1:0] AddrSpare = 3'd4;
   localparam int                      SettleCycles = 6;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [CharWidth-1:0]    req_tdata   = '0;   // [15:0] char_code
   logic                    req_tlast   = 1'b0; // text_end
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [CharWidth-1:0]    rsp_tdata;          // [15:0] out_char
   logic                    rsp_tlast;          // run_last
   logic [0:0]              rsp_tuser;          // [0] out_text_end
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int   mismatches, units_pending, requests_seen, units_seen;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   masks_applied = 0;
   bit   rx_hold = 1'b0;

   always #4 clock = ~clock;

   markup_entity_escaper_unit u_dut (.*);

   mee_stream_checker u_checker (.*);

   always @(negedge clock) begin
      rsp_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [CharWidth-1:0] escapable(int slot);
      case (slot)
         0:       return 16'h0026;
         1:       return 16'h003C;
         2:       return 16'h003E;
         3:       return 16'h0022;
         4:       return 16'h00A0;
         5:       return 16'h0009;
         6:       return 16'h000A;
         default: return 16'h000D;
      endcase
   endfunction

   task automatic csr_access(input logic wr, input logic [CsrAddrWidth-1:0] addr,
                             input logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_mask(input logic [EntCount-1:0] mask);
      csr_access(1'b1, AddrMask, CsrDataWidth'(mask));
      csr_access(1'b0, AddrMask, '0);
      masks_applied++;
   endtask

   task automatic send_unit(input logic [CharWidth-1:0] code, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops the request valid and waits until every expected unit has come out.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (units_pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Escapable characters in half the picks, mixed with plain units and edge codes.
   task automatic send_random_unit();
      int                   pick;
      logic [CharWidth-1:0] code;
      pick = $urandom_range(9);
      if (pick < 5) begin
         code = escapable($urandom_range(7));
      end else if (pick < 7) begin
         code = {8'h00, 8'($urandom_range(255))};
      end else if (pick < 9) begin
         code = 16'($urandom_range(65535));
      end else begin
         case ($urandom_range(3))
            0:       code = 16'h0000;
            1:       code = 16'hFFFF;
            2:       code = 16'hFF26;
            default: code = 16'h013C;
         endcase
      end
      send_unit(code, $urandom_range(3) == 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset value of the mask, then every escapable character and plain extremes.
      csr_access(1'b0, AddrMask, '0);
      for (int i = 0; i < EntCount; i++) send_unit(escapable(i), i[0]);
      send_unit(16'h0000, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      send_unit(16'h0126, 1'b0);
      send_unit(16'h00A1, 1'b1);
      send_unit(16'h0041, 1'b0);
      drain_results();

      // All entities disabled; a write to the unused address must leave the mask alone.
      set_mask(8'h00);
      csr_access(1'b1, AddrSpare, 32'hFFFF_FFFF);
      csr_access(1'b0, AddrMask, '0);
      for (int i = 0; i < EntCount; i++) send_unit(escapable(i), !i[0]);
      drain_results();

      // No idling; the receiver holds off long enough to back up the request side.
      set_mask(8'hFF);
      fork
         begin
            @(posedge clock);
            rx_hold = 1'b1;
            repeat (80) @(posedge clock);
            rx_hold = 1'b0;
         end
         repeat (40) send_random_unit();
      join
      drain_results();

      send_idle_pct = 70;
      set_mask(8'h55);
      repeat (20) send_random_unit();
      drain_results();
      repeat (20) send_random_unit();
      drain_results();

      send_idle_pct  = 0;
      recv_stall_pct = 70;
      set_mask(8'hAA);
      repeat (40) send_random_unit();
      drain_results();

      send_idle_pct  = 32;
      recv_stall_pct = 32;
      set_mask(8'($urandom_range(255)));
      repeat (40) send_random_unit();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (units_pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests and %0d result units under %0d mask settings,",
               requests_seen, units_seen, masks_applied + 1);
      $display("with sender gaps, receiver stalls, a long hold-off and drained pauses.");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
